// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/urdm_pkg.sv -----
`default_nettype none

package urdm_pkg;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RX      = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_CRC     = 3'd2,
    ST_HEADER  = 3'd3,
    ST_BUSY    = 3'd4
  } status_e;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic [2:0]  status;
    logic [31:0] read_data;
  } out_t;

  // One entry of the queue between the front and back ends.
  typedef struct packed {
    logic        report;
    logic        write;
    logic [6:0]  reg_address;
    logic [7:0]  slave_address;
    logic [2:0]  status;
    logic [31:0] data;
  } job_t;

  // CRC8, polynomial 0x07, byte fed LSB first.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/urdm_front.sv -----
`default_nettype none

module urdm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [7:0]     cfg_wdata_i,
  input  wire logic           accept_i,
  input  wire urdm_pkg::in_t  item_i,
  output logic                job_push_o,
  output urdm_pkg::job_t      job_o
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_RD_ECHO  = 4'b0010,
    PH_RD_REPLY = 4'b0100,
    PH_WR_ECHO  = 4'b1000
  } phase_e;

  localparam logic [2:0] READ_ECHO_LAST  = 3'd3;
  localparam logic [2:0] WRITE_ECHO_LAST = 3'd7;
  localparam logic [2:0] REPLY_LAST      = 3'd7;

  phase_e      phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic [6:0]  pend_q, pend_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  slave_q;
  logic [7:0]  store_q [7];
  logic        store_we;
  urdm_pkg::cmd_e cmd;

  assign cmd = urdm_pkg::cmd_e'(item_i.cmd);

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    pend_d     = pend_q;
    crc_d      = crc_q;
    store_we   = 1'b0;
    job_push_o = 1'b0;
    job_o.report        = 1'b1;
    job_o.write         = 1'b0;
    job_o.reg_address   = item_i.reg_address;
    job_o.slave_address = slave_q;
    job_o.status        = urdm_pkg::ST_OK;
    job_o.data          = '0;
    if (accept_i) begin
      case (cmd)
        urdm_pkg::CMD_READ, urdm_pkg::CMD_WRITE: begin
          job_push_o = 1'b1;
          if (phase_q != PH_IDLE) begin
            job_o.status = urdm_pkg::ST_BUSY;
          end else begin
            job_o.report = 1'b0;
            job_o.write  = (cmd == urdm_pkg::CMD_WRITE);
            job_o.data   = item_i.write_data;
            pend_d  = item_i.reg_address;
            count_d = '0;
            crc_d   = '0;
            phase_d = (cmd == urdm_pkg::CMD_WRITE) ? PH_WR_ECHO : PH_RD_ECHO;
          end
        end
        urdm_pkg::CMD_TIMEOUT: begin
          if (phase_q != PH_IDLE) begin
            job_push_o   = 1'b1;
            job_o.status = (phase_q == PH_WR_ECHO) ? urdm_pkg::ST_OK : urdm_pkg::ST_TIMEOUT;
            phase_d = PH_IDLE;
            count_d = '0;
          end
        end
        urdm_pkg::CMD_RX: begin
          case (phase_q)
            PH_RD_ECHO: begin
              if (count_q == READ_ECHO_LAST) begin
                phase_d = PH_RD_REPLY;
                count_d = '0;
                crc_d   = '0;
              end else begin
                count_d = count_q + 3'd1;
              end
            end
            PH_WR_ECHO: begin
              if (count_q == WRITE_ECHO_LAST) begin
                phase_d    = PH_IDLE;
                count_d    = '0;
                job_push_o = 1'b1;
              end else begin
                count_d = count_q + 3'd1;
              end
            end
            PH_RD_REPLY: begin
              if (count_q != REPLY_LAST) begin
                store_we = 1'b1;
                crc_d    = urdm_pkg::crc8_feed(crc_q, item_i.rx_byte);
                count_d  = count_q + 3'd1;
              end else begin
                phase_d    = PH_IDLE;
                count_d    = '0;
                job_push_o = 1'b1;
                // CRC check takes precedence over the header check
                if (crc_q != item_i.rx_byte) begin
                  job_o.status = urdm_pkg::ST_CRC;
                end else if (store_q[0] != urdm_pkg::SYNC_BYTE ||
                             store_q[1] != urdm_pkg::MASTER_ADDR ||
                             store_q[2] != {1'b0, pend_q}) begin
                  job_o.status = urdm_pkg::ST_HEADER;
                end else begin
                  job_o.data = {store_q[3], store_q[4], store_q[5], store_q[6]};
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      pend_q  <= '0;
      crc_q   <= '0;
      slave_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      crc_q   <= crc_d;
      if (cfg_we_i) begin
        slave_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= item_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/urdm_jobq.sv -----
`default_nettype none

module urdm_jobq #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire urdm_pkg::job_t data_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output urdm_pkg::job_t      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urdm_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/urdm_back.sv -----
`default_nettype none

`include "assert_macros.svh"

module urdm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire urdm_pkg::job_t job_i,
  output logic                job_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output urdm_pkg::out_t      result_o
);

  logic [2:0]      idx_q;
  logic [7:0]      crc_q;
  logic            oval_q;
  urdm_pkg::out_t  out_q;
  urdm_pkg::out_t  word;
  logic            out_free, load, last;
  logic [2:0]      len_last;
  logic [7:0]      tx;
  logic            rpt_out, rpt_clean, run_end;

  assign out_free = !oval_q || pop_i;
  assign load     = job_valid_i && out_free;
  assign len_last = job_i.write ? 3'd7 : 3'd3;
  assign last     = (idx_q == len_last);

  always_comb begin
    if (last) begin
      tx = crc_q;
    end else begin
      case (idx_q)
        3'd0:    tx = urdm_pkg::SYNC_BYTE;
        3'd1:    tx = job_i.slave_address;
        3'd2:    tx = {job_i.write, job_i.reg_address};
        3'd3:    tx = job_i.data[31:24];
        3'd4:    tx = job_i.data[23:16];
        3'd5:    tx = job_i.data[15:8];
        default: tx = job_i.data[7:0];
      endcase
    end
  end

  always_comb begin
    if (job_i.report) begin
      word.kind        = urdm_pkg::KIND_REPORT;
      word.tx_byte     = '0;
      word.last_of_run = 1'b0;
      word.status      = job_i.status;
      word.read_data   = job_i.data;
    end else begin
      word.kind        = urdm_pkg::KIND_TX;
      word.tx_byte     = tx;
      word.last_of_run = last;
      word.status      = urdm_pkg::ST_OK;
      word.read_data   = '0;
    end
  end

  assign job_pop_o = load && (job_i.report || last);
  assign empty_o   = !oval_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      crc_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      if (load && !job_i.report) begin
        if (last) begin
          idx_q <= '0;
          crc_q <= '0;
        end else begin
          idx_q <= idx_q + 3'd1;
          crc_q <= urdm_pkg::crc8_feed(crc_q, tx);
        end
      end
      if (load) begin
        oval_q <= 1'b1;
      end else if (pop_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // hold the word until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word;
    end
  end

  assign rpt_out   = oval_q && (out_q.kind == urdm_pkg::KIND_REPORT);
  assign rpt_clean = (out_q.tx_byte == 8'd0) && !out_q.last_of_run;
  assign run_end   = load && !job_i.report && last;

  `ASSERT_IMPL(a_idx_needs_request, idx_q != 3'd0, job_valid_i && !job_i.report, "no request")
  `ASSERT_IMPL(a_report_clean, rpt_out, rpt_clean, "report word carries transmit fields")
  `ASSERT_NEXT(a_run_restarts, run_end, idx_q == 3'd0 && crc_q == 8'd0, "serialiser not rewound")

endmodule

`default_nettype wire

// ----- rtl/uart_register_datagram_master_unit.sv -----
`default_nettype none

// Master side of a single-wire UART register protocol with CRC8 (poly 0x07, init 0,
// LSB first). Push one command word per cycle while full is low: read start, write
// start, received bus byte or timeout tick. Each word is decoded at once by the front
// end and leaves at most one job in a JOBQ_DEPTH-entry queue; the back end turns a
// job into result words at one word per cycle, stalling while a word waits for pop:
// a read request gives 4 words, a write request 8 (the CRC is built byte by byte as
// the datagram is sent), and a completion report 1. Sustained rate is therefore set
// by the back-end serialiser; full rises only when the job queue fills. Results
// appear on result_o while empty is low and are taken with pop. Write slave_address
// through cfg_we_i and cfg_wdata_i while idle.
module uart_register_datagram_master_unit #(
  parameter int JOBQ_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          push,
  output logic               full,
  input  wire urdm_pkg::in_t item_i,
  output logic               empty,
  input  wire logic          pop,
  output urdm_pkg::out_t     result_o
);

  logic           accept;
  logic           job_push, job_pop, job_valid;
  urdm_pkg::job_t job_in, job_head;

  assign accept = push && !full;

  urdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  urdm_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .full_o  (full),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  urdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- verif/urdm_master_checker.sv -----
`default_nettype none

module urdm_master_checker
  import urdm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        push,
  input  wire logic        full,
  input  wire in_t         item_i,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire out_t        result_o,
  output int               mismatches_o,
  output int               owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_READ_ECHO,
    LINK_READ_REPLY,
    LINK_WRITE_ECHO
  } link_e;

  link_e       link;
  int          count;
  logic [6:0]  pend_reg;
  logic [7:0]  reply_crc;
  logic [7:0]  reply [8];
  logic [7:0]  node_addr;
  out_t        master_out_q [$];
  int          mismatches = 0;

  function automatic logic [7:0] crc8_lsb(logic [7:0] acc, logic [7:0] data);
    for (int i = 0; i < 8; i++) begin
      acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ data[i]) ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  task automatic owe(logic k, logic [7:0] tx, logic last, status_e st, logic [31:0] d);
    out_t o;
    o.kind        = k;
    o.tx_byte     = tx;
    o.last_of_run = last;
    o.status      = st;
    o.read_data   = d;
    master_out_q.push_back(o);
  endtask

  task automatic master_step(in_t w);
    logic [7:0] dg [8];
    logic [7:0] acc;
    int         len;
    case (w.cmd)
      CMD_READ, CMD_WRITE: begin
        if (link != LINK_IDLE) begin
          owe(KIND_REPORT, 8'h00, 1'b0, ST_BUSY, 32'h0);
        end else begin
          dg[0] = SYNC_BYTE;
          dg[1] = node_addr;
          if (w.cmd == CMD_READ) begin
            dg[2] = {1'b0, w.reg_address};
            len   = 4;
          end else begin
            dg[2] = {1'b1, w.reg_address};
            dg[3] = w.write_data[31:24];
            dg[4] = w.write_data[23:16];
            dg[5] = w.write_data[15:8];
            dg[6] = w.write_data[7:0];
            len   = 8;
          end
          acc = 8'h00;
          for (int i = 0; i < len - 1; i++) acc = crc8_lsb(acc, dg[i]);
          dg[len-1] = acc;
          for (int i = 0; i < len; i++) begin
            owe(KIND_TX, dg[i], i == len - 1, ST_OK, 32'h0);
          end
          pend_reg  = w.reg_address;
          count     = 0;
          reply_crc = 8'h00;
          link      = (w.cmd == CMD_READ) ? LINK_READ_ECHO : LINK_WRITE_ECHO;
        end
      end
      CMD_TIMEOUT: begin
        if (link != LINK_IDLE) begin
          owe(KIND_REPORT, 8'h00, 1'b0, (link == LINK_WRITE_ECHO) ? ST_OK : ST_TIMEOUT,
              32'h0);
          link  = LINK_IDLE;
          count = 0;
        end
      end
      default: begin
        case (link)
          LINK_READ_ECHO: begin
            count++;
            if (count >= 4) begin
              link      = LINK_READ_REPLY;
              count     = 0;
              reply_crc = 8'h00;
            end
          end
          LINK_WRITE_ECHO: begin
            count++;
            if (count >= 8) begin
              link  = LINK_IDLE;
              count = 0;
              owe(KIND_REPORT, 8'h00, 1'b0, ST_OK, 32'h0);
            end
          end
          LINK_READ_REPLY: begin
            reply[count] = w.rx_byte;
            if (count < 7) begin
              reply_crc = crc8_lsb(reply_crc, w.rx_byte);
              count++;
            end else begin
              link  = LINK_IDLE;
              count = 0;
              // CRC first, then the header
              if (reply_crc != reply[7]) begin
                owe(KIND_REPORT, 8'h00, 1'b0, ST_CRC, 32'h0);
              end else if (reply[0] != SYNC_BYTE || reply[1] != MASTER_ADDR ||
                           reply[2] != {1'b0, pend_reg}) begin
                owe(KIND_REPORT, 8'h00, 1'b0, ST_HEADER, 32'h0);
              end else begin
                owe(KIND_REPORT, 8'h00, 1'b0, ST_OK,
                    {reply[3], reply[4], reply[5], reply[6]});
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s differs, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      link      = LINK_IDLE;
      count     = 0;
      pend_reg  = '0;
      reply_crc = '0;
      node_addr = '0;
      master_out_q.delete();
    end else begin
      if (cfg_we_i) node_addr = cfg_wdata_i;
      // predict before comparing so a same-edge word is already owed
      if (push && !full) master_step(item_i);
      if (pop && !empty) begin
        if (master_out_q.size() == 0) begin
          mismatches++;
          $display("%0t: stray word, expected none, got %h", $time, result_o);
        end else begin
          want = master_out_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(result_o.kind));
          check_field("tx_byte", 32'(want.tx_byte), 32'(result_o.tx_byte));
          check_field("last_of_run", 32'(want.last_of_run), 32'(result_o.last_of_run));
          check_field("status", 32'(want.status), 32'(result_o.status));
          check_field("read_data", want.read_data, result_o.read_data);
        end
      end
    end
    mismatches_o <= mismatches;
    owed_o       <= master_out_q.size();
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import urdm_pkg::*;

  typedef enum int {
    CLEAN,
    BAD_CRC,
    BAD_SYNC,
    BAD_MASTER,
    BAD_REG,
    LOST_ECHO,
    LOST_REPLY
  } flaw_e;

  localparam int QUIET_LIMIT = 3000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       push        = 1'b0;
  logic       pop         = 1'b0;
  in_t        item_i      = '0;
  logic       full;
  logic       empty;
  out_t       result_o;

  int mismatches;
  int owed;
  bit calm       = 1'b0;
  int tallied    = 0;
  int stall_left = 0;

  always #4 clk_i = ~clk_i;

  uart_register_datagram_master_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  urdm_master_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  // receiver: stall in bursts unless calm
  always @(posedge clk_i) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_t word(cmd_e c, logic [6:0] r, logic [31:0] d, logic [7:0] b);
    in_t w;
    w.cmd         = c;
    w.reg_address = r;
    w.write_data  = d;
    w.rx_byte     = b;
    return w;
  endfunction

  task automatic send(in_t w, bit tally);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (full);
    tallied += tally;
  endtask

  task automatic rx(logic [7:0] b, bit tally = 1'b1);
    send(word(CMD_RX, 7'($urandom), $urandom, b), tally);
  endtask

  task automatic tick(bit tally = 1'b1);
    send(word(CMD_TIMEOUT, 7'($urandom), $urandom, 8'($urandom)), tally);
  endtask

  task automatic start(cmd_e c, logic [6:0] r, logic [31:0] d);
    send(word(c, r, d, 8'($urandom)), 1'b1);
  endtask

  // now and then a start that lands mid-transaction
  task automatic maybe_busy;
    if ($urandom_range(0, 5) == 0) begin
      start(cmd_e'($urandom_range(0, 1)), 7'($urandom), $urandom);
    end
  endtask

  task automatic read_txn(logic [6:0] r, logic [31:0] d, flaw_e flaw);
    logic [7:0] reply [8];
    logic [7:0] acc;
    int         cut;
    start(CMD_READ, r, $urandom);
    cut = (flaw == LOST_ECHO) ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < cut; i++) begin
      maybe_busy();
      rx(8'($urandom));
    end
    if (flaw == LOST_ECHO) begin
      tick();
      return;
    end
    reply[0] = SYNC_BYTE;
    reply[1] = MASTER_ADDR;
    reply[2] = {1'b0, r};
    reply[3] = d[31:24];
    reply[4] = d[23:16];
    reply[5] = d[15:8];
    reply[6] = d[7:0];
    case (flaw)
      BAD_SYNC:   reply[0] ^= 8'($urandom_range(1, 255));
      BAD_MASTER: reply[1] ^= 8'($urandom_range(1, 255));
      BAD_REG:    reply[2] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    acc = 8'h00;
    for (int i = 0; i < 7; i++) acc = crc8_feed(acc, reply[i]);
    reply[7] = acc;
    if (flaw == BAD_CRC) begin
      reply[7] ^= 8'($urandom_range(1, 255));
      // a broken header as well must still read as a CRC fault
      if ($urandom_range(0, 1) == 1) reply[0] ^= 8'($urandom_range(1, 255));
    end
    cut = (flaw == LOST_REPLY) ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < cut; i++) begin
      maybe_busy();
      rx(reply[i]);
    end
    if (flaw == LOST_REPLY) tick();
  endtask

  task automatic write_txn(logic [6:0] r, logic [31:0] d, bit lost);
    int cut;
    start(CMD_WRITE, r, d);
    cut = lost ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < cut; i++) begin
      maybe_busy();
      rx(8'($urandom));
    end
    if (lost) tick();
  endtask

  task automatic random_transaction;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      read_txn(7'($urandom), $urandom,
               ($urandom_range(0, 9) < 7) ? CLEAN : flaw_e'($urandom_range(1, 6)));
    end else if (r < 85) begin
      write_txn(7'($urandom), $urandom, $urandom_range(0, 4) == 0);
    end else if (r < 92) begin
      rx(8'($urandom), 1'b0);
    end else begin
      tick(1'b0);
    end
  endtask

  // drain, let the back end settle, then write the address
  task automatic set_slave(logic [7:0] a);
    push <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] plan   [4];
    int         bounds [4];
    plan   = '{8'hFF, 8'($urandom), 8'h80, 8'($urandom)};
    bounds = '{140, 240, 340, 420};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_slave(8'h00);

    rx(8'($urandom), 1'b0);
    tick(1'b0);
    start(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF);
    start(CMD_READ, 7'($urandom), $urandom);
    start(CMD_WRITE, 7'($urandom), $urandom);
    tick();
    read_txn(7'h00, 32'h0, LOST_ECHO);
    read_txn(7'h7F, 32'hFFFF_FFFF, CLEAN);
    write_txn(7'h00, 32'h0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      set_slave(plan[p]);
      calm = (p == 3);
      while (tallied < bounds[p]) random_transaction();
    end
    push <= 1'b0;
    @(posedge clk_i);

    while (owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // advance only while words move; give up after a long silence
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
